>>> rtl/ica_pkg.sv
`default_nettype none

package ica_pkg;

	localparam int FIELD_WIDTH = 32;
	localparam int OPERAND_WIDTH = 32;
	localparam int VALUE_WIDTH = 64;
	localparam int HALF_WIDTH = VALUE_WIDTH / 2;
	localparam int EXP_WIDTH = OPERAND_WIDTH - 1;
	localparam int DIV_STEPS = VALUE_WIDTH;

	localparam logic signed [VALUE_WIDTH-1:0] FACT_LIMIT = 64'sd20;

	// Operation codes.
	localparam logic [2:0] K_ADD = 3'd0;
	localparam logic [2:0] K_SUB = 3'd1;
	localparam logic [2:0] K_QUO = 3'd2;
	localparam logic [2:0] K_REM = 3'd3;
	localparam logic [2:0] K_MUL = 3'd4;
	localparam logic [2:0] K_POW = 3'd5;
	localparam logic [2:0] K_FACT = 3'd6;
	localparam logic [2:0] K_BINOM = 3'd7;

	// Result status codes.
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_DOMAIN = 2'd1;
	localparam logic [1:0] ST_DIVZERO = 2'd2;
	localparam logic [1:0] ST_OVERFLOW = 2'd3;

	// How an item is processed once decoded.
	localparam logic [2:0] CLS_DONE = 3'd0;
	localparam logic [2:0] CLS_MUL = 3'd1;
	localparam logic [2:0] CLS_DIV = 3'd2;
	localparam logic [2:0] CLS_POW = 3'd3;
	localparam logic [2:0] CLS_BINOM = 3'd4;

	// Datapath write-back selects.
	localparam logic [2:0] WB_NONE = 3'd0;
	localparam logic [2:0] WB_SETUP = 3'd1;
	localparam logic [2:0] WB_MULRES = 3'd2;
	localparam logic [2:0] WB_ACC = 3'd3;
	localparam logic [2:0] WB_BASE = 3'd4;
	localparam logic [2:0] WB_POWRES = 3'd5;
	localparam logic [2:0] WB_DIVRES = 3'd6;

	// Multiplier operand selects.
	localparam logic [1:0] MS_OPS = 2'd0;
	localparam logic [1:0] MS_DEN = 2'd1;
	localparam logic [1:0] MS_ACC = 2'd2;
	localparam logic [1:0] MS_SQR = 2'd3;

	// Divider operand selects.
	localparam logic DS_OPS = 1'b0;
	localparam logic DS_BINOM = 1'b1;

	typedef struct packed {
		logic [2:0] kind;
		logic signed [FIELD_WIDTH-1:0] operand_a;
		logic signed [FIELD_WIDTH-1:0] operand_b;
	} in_t;

	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] value;
		logic [1:0] status;
	} out_t;

	typedef struct packed {
		logic load_in;
		logic [2:0] wb;
		logic mul_start;
		logic [1:0] mul_sel;
		logic div_start;
		logic div_sel;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic [2:0] cls;
		logic mul_done;
		logic div_done;
		logic exp_zero;
		logic exp_odd;
	} sts_t;

	// Keep the low OPERAND_WIDTH bits and sign-extend them.
	function automatic logic [VALUE_WIDTH-1:0] sext_w(input logic [VALUE_WIDTH-1:0] v);
		return {{(VALUE_WIDTH-OPERAND_WIDTH){v[OPERAND_WIDTH-1]}}, v[OPERAND_WIDTH-1:0]};
	endfunction

	function automatic logic [VALUE_WIDTH-1:0] fact_lut(input logic [4:0] n);
		logic [VALUE_WIDTH-1:0] r;
		case (n)
			5'd0: r = 64'd1;
			5'd1: r = 64'd1;
			5'd2: r = 64'd2;
			5'd3: r = 64'd6;
			5'd4: r = 64'd24;
			5'd5: r = 64'd120;
			5'd6: r = 64'd720;
			5'd7: r = 64'd5040;
			5'd8: r = 64'd40320;
			5'd9: r = 64'd362880;
			5'd10: r = 64'd3628800;
			5'd11: r = 64'd39916800;
			5'd12: r = 64'd479001600;
			5'd13: r = 64'd6227020800;
			5'd14: r = 64'd87178291200;
			5'd15: r = 64'd1307674368000;
			5'd16: r = 64'd20922789888000;
			5'd17: r = 64'd355687428096000;
			5'd18: r = 64'd6402373705728000;
			5'd19: r = 64'd121645100408832000;
			5'd20: r = 64'd2432902008176640000;
			default: r = 64'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/integer_calculator_alu.sv
// Integer calculator: add, subtract, truncating quotient and remainder,
// multiply, power, factorial and binomial coefficient on signed operands.
// Request channel (req_valid, req_stall, req) carries kind, operand_a and
// operand_b; response channel (rsp_valid, rsp_stall, rsp) carries a 64-bit
// value and a 2-bit status. An item moves when valid is high and stall low.
// One item is worked on at a time. How each kind is worked out:
//   add, subtract, factorial and all error cases: formed at decode
//   multiply: three 32x32 partial products and a final add
//   quotient, remainder: one quotient bit per cycle
//   binomial: denominator product, then the 64-step divide
//   power: for each exponent bit, a multiply on a set bit, then a square
// The divider is iterative and the multiplier is shared.
// req_stall is low only while the controller is idle; a finished result
// sits in the output register, so a new item is taken while it waits.
// If rsp_stall holds the result, the next item completes and then waits
// until the output register frees. Reset clears the controller and the
// response valid; no item in flight survives it.
`default_nettype none

module integer_calculator_alu
	import ica_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_stall,
	input wire in_t req,
	output logic rsp_valid,
	input wire logic rsp_stall,
	output out_t rsp
);

	cmd_t cmd;
	sts_t sts;

	ica_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.sts(sts),
		.cmd(cmd)
	);

	ica_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.cmd(cmd),
		.sts(sts),
		.rsp(rsp)
	);

endmodule

`default_nettype wire

>>> rtl/ica_mul.sv
`default_nettype none

// Low half of a 64 by 64 product, built from one 32 by 32 multiplier
// in turns: the low partial, two cross partials, then the final add.
module ica_mul
	import ica_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [VALUE_WIDTH-1:0] x,
	input wire logic [VALUE_WIDTH-1:0] y,
	output logic done,
	output logic [VALUE_WIDTH-1:0] prod
);

	logic [VALUE_WIDTH-1:0] x_q, y_q, lo_q, prod_q;
	logic [HALF_WIDTH-1:0] hi_q;
	logic [1:0] step_q;
	logic busy_q, done_q;
	logic [HALF_WIDTH-1:0] mx, my;
	logic [VALUE_WIDTH-1:0] m;

	always_comb begin
		case (step_q)
			2'd0: begin
				mx = x_q[HALF_WIDTH-1:0];
				my = y_q[HALF_WIDTH-1:0];
			end
			2'd1: begin
				mx = x_q[HALF_WIDTH-1:0];
				my = y_q[VALUE_WIDTH-1:HALF_WIDTH];
			end
			default: begin
				mx = x_q[VALUE_WIDTH-1:HALF_WIDTH];
				my = y_q[HALF_WIDTH-1:0];
			end
		endcase
		m = {{HALF_WIDTH{1'b0}}, mx} * {{HALF_WIDTH{1'b0}}, my};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 2'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 2'd0;
			end else if (busy_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x;
			y_q <= y;
		end else if (busy_q) begin
			case (step_q)
				2'd0: lo_q <= m;
				2'd1: hi_q <= m[HALF_WIDTH-1:0];
				2'd2: hi_q <= hi_q + m[HALF_WIDTH-1:0];
				default: prod_q <= {lo_q[VALUE_WIDTH-1:HALF_WIDTH] + hi_q,
					lo_q[HALF_WIDTH-1:0]};
			endcase
		end
	end

	assign done = done_q;
	assign prod = prod_q;

endmodule

`default_nettype wire

>>> rtl/ica_div.sv
`default_nettype none

// Unsigned 64-bit restoring divider, one quotient bit per cycle.
module ica_div
	import ica_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [VALUE_WIDTH-1:0] dividend,
	input wire logic [VALUE_WIDTH-1:0] divisor,
	output logic done,
	output logic [VALUE_WIDTH-1:0] quo,
	output logic [VALUE_WIDTH-1:0] rem
);

	localparam int CNT_W = $clog2(DIV_STEPS);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(DIV_STEPS - 1);

	logic [VALUE_WIDTH-1:0] q_q, r_q, d_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q, done_q;
	logic [VALUE_WIDTH:0] rs;
	logic [VALUE_WIDTH+1:0] diff;

	assign rs = {r_q, q_q[VALUE_WIDTH-1]};
	assign diff = {1'b0, rs} - {2'b00, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			q_q <= {q_q[VALUE_WIDTH-2:0], ~diff[VALUE_WIDTH+1]};
			r_q <= diff[VALUE_WIDTH+1] ? rs[VALUE_WIDTH-1:0] : diff[VALUE_WIDTH-1:0];
		end
	end

	assign done = done_q;
	assign quo = q_q;
	assign rem = r_q;

endmodule

`default_nettype wire

>>> rtl/ica_dp.sv
`default_nettype none

module ica_dp
	import ica_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire in_t req,
	input wire cmd_t cmd,
	output sts_t sts,
	output out_t rsp
);

	logic [2:0] kind_q;
	logic signed [VALUE_WIDTH-1:0] a_q, b_q;
	logic [VALUE_WIDTH-1:0] base_q, acc_q, res_q;
	logic [EXP_WIDTH-1:0] exp_q;
	logic [1:0] st_q;
	out_t out_q;

	logic a_neg, b_neg, b_zero, a_big, binom_bad;
	logic [4:0] n5, k5, nk5;
	logic [VALUE_WIDTH-1:0] abs_a, abs_b;
	logic [2:0] cls;
	logic [VALUE_WIDTH-1:0] imm_val;
	logic [1:0] imm_st;
	logic [VALUE_WIDTH-1:0] mul_x, mul_y, mul_prod;
	logic [VALUE_WIDTH-1:0] div_n, div_d, div_q, div_r, q_fix, r_fix, div_res;
	logic mul_done, div_done;

	assign a_neg = a_q[VALUE_WIDTH-1];
	assign b_neg = b_q[VALUE_WIDTH-1];
	assign b_zero = (b_q == '0);
	assign a_big = (a_q > FACT_LIMIT);
	assign binom_bad = a_neg || b_neg || (b_q > a_q);
	assign n5 = a_q[4:0];
	assign k5 = b_q[4:0];
	assign nk5 = n5 - k5;
	assign abs_a = a_neg ? '0 - a_q : a_q;
	assign abs_b = b_neg ? '0 - b_q : b_q;

	// Decode: results that need no iteration are formed here.
	always_comb begin
		cls = CLS_DONE;
		imm_val = '0;
		imm_st = ST_OK;
		case (kind_q)
			K_ADD: imm_val = sext_w(a_q + b_q);
			K_SUB: imm_val = sext_w(a_q - b_q);
			K_QUO, K_REM: begin
				if (b_zero) begin
					imm_st = ST_DIVZERO;
				end else begin
					cls = CLS_DIV;
				end
			end
			K_MUL: cls = CLS_MUL;
			K_POW: begin
				if (b_neg) begin
					imm_val = '1;
					imm_st = ST_DOMAIN;
				end else begin
					cls = CLS_POW;
				end
			end
			K_FACT: begin
				if (a_neg) begin
					imm_val = '1;
					imm_st = ST_DOMAIN;
				end else if (a_big) begin
					imm_st = ST_OVERFLOW;
				end else begin
					imm_val = fact_lut(n5);
				end
			end
			default: begin
				// The domain test comes before the overflow test.
				if (binom_bad) begin
					imm_val = '1;
					imm_st = ST_DOMAIN;
				end else if (a_big) begin
					imm_st = ST_OVERFLOW;
				end else begin
					cls = CLS_BINOM;
				end
			end
		endcase
	end

	always_comb begin
		case (cmd.mul_sel)
			MS_OPS: begin
				mul_x = a_q;
				mul_y = b_q;
			end
			MS_DEN: begin
				mul_x = fact_lut(nk5);
				mul_y = fact_lut(k5);
			end
			MS_ACC: begin
				mul_x = acc_q;
				mul_y = base_q;
			end
			default: begin
				mul_x = base_q;
				mul_y = base_q;
			end
		endcase
	end

	// Binomial divides n! by the product (n-k)! k! just formed by the multiplier.
	assign div_n = (cmd.div_sel == DS_BINOM) ? fact_lut(n5) : abs_a;
	assign div_d = (cmd.div_sel == DS_BINOM) ? mul_prod : abs_b;

	ica_mul u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.mul_start),
		.x(mul_x),
		.y(mul_y),
		.done(mul_done),
		.prod(mul_prod)
	);

	ica_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.div_start),
		.dividend(div_n),
		.divisor(div_d),
		.done(div_done),
		.quo(div_q),
		.rem(div_r)
	);

	// Truncating division: quotient sign from both operands, remainder from the dividend.
	assign q_fix = (a_neg ^ b_neg) ? '0 - div_q : div_q;
	assign r_fix = a_neg ? '0 - div_r : div_r;

	always_comb begin
		case (kind_q)
			K_QUO: div_res = sext_w(q_fix);
			K_REM: div_res = sext_w(r_fix);
			default: div_res = div_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			kind_q <= req.kind;
			a_q <= sext_w({{(VALUE_WIDTH-FIELD_WIDTH){1'b0}}, req.operand_a});
			b_q <= sext_w({{(VALUE_WIDTH-FIELD_WIDTH){1'b0}}, req.operand_b});
		end
		case (cmd.wb)
			WB_SETUP: begin
				res_q <= imm_val;
				st_q <= imm_st;
				base_q <= a_q;
				acc_q <= {{(VALUE_WIDTH-1){1'b0}}, 1'b1};
				exp_q <= b_q[EXP_WIDTH-1:0];
			end
			WB_MULRES: res_q <= sext_w(mul_prod);
			WB_ACC: acc_q <= mul_prod;
			WB_BASE: begin
				base_q <= mul_prod;
				exp_q <= exp_q >> 1;
			end
			WB_POWRES: res_q <= acc_q;
			WB_DIVRES: res_q <= div_res;
			default: ;
		endcase
		if (cmd.load_out) begin
			out_q.value <= res_q;
			out_q.status <= st_q;
		end
	end

	assign sts.cls = cls;
	assign sts.mul_done = mul_done;
	assign sts.div_done = div_done;
	assign sts.exp_zero = (exp_q == '0);
	assign sts.exp_odd = exp_q[0];
	assign rsp = out_q;

endmodule

`default_nettype wire

>>> rtl/ica_ctrl.sv
`default_nettype none

module ica_ctrl
	import ica_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_stall,
	output logic rsp_valid,
	input wire logic rsp_stall,
	input wire sts_t sts,
	output cmd_t cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SETUP = 3'd1;
	localparam logic [2:0] S_MULW = 3'd2;
	localparam logic [2:0] S_DIVW = 3'd3;
	localparam logic [2:0] S_PTEST = 3'd4;
	localparam logic [2:0] S_PMULW = 3'd5;
	localparam logic [2:0] S_PSQW = 3'd6;
	localparam logic [2:0] S_FINISH = 3'd7;

	logic [2:0] state_q, state_d;
	logic rsp_valid_q;
	logic out_free;

	assign req_stall = (state_q != S_IDLE);
	assign out_free = !rsp_valid_q || !rsp_stall;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.wb = WB_NONE;
		cmd.mul_sel = MS_OPS;
		cmd.div_sel = DS_OPS;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load_in = 1'b1;
					state_d = S_SETUP;
				end
			end
			S_SETUP: begin
				cmd.wb = WB_SETUP;
				case (sts.cls)
					CLS_MUL: begin
						cmd.mul_start = 1'b1;
						cmd.mul_sel = MS_OPS;
						state_d = S_MULW;
					end
					CLS_BINOM: begin
						cmd.mul_start = 1'b1;
						cmd.mul_sel = MS_DEN;
						state_d = S_MULW;
					end
					CLS_DIV: begin
						cmd.div_start = 1'b1;
						cmd.div_sel = DS_OPS;
						state_d = S_DIVW;
					end
					CLS_POW: state_d = S_PTEST;
					default: state_d = S_FINISH;
				endcase
			end
			S_MULW: begin
				if (sts.mul_done) begin
					if (sts.cls == CLS_BINOM) begin
						cmd.div_start = 1'b1;
						cmd.div_sel = DS_BINOM;
						state_d = S_DIVW;
					end else begin
						cmd.wb = WB_MULRES;
						state_d = S_FINISH;
					end
				end
			end
			S_DIVW: begin
				if (sts.div_done) begin
					cmd.wb = WB_DIVRES;
					state_d = S_FINISH;
				end
			end
			S_PTEST: begin
				// One exponent bit per pass: multiply on a set bit, then square.
				if (sts.exp_zero) begin
					cmd.wb = WB_POWRES;
					state_d = S_FINISH;
				end else if (sts.exp_odd) begin
					cmd.mul_start = 1'b1;
					cmd.mul_sel = MS_ACC;
					state_d = S_PMULW;
				end else begin
					cmd.mul_start = 1'b1;
					cmd.mul_sel = MS_SQR;
					state_d = S_PSQW;
				end
			end
			S_PMULW: begin
				if (sts.mul_done) begin
					cmd.wb = WB_ACC;
					cmd.mul_start = 1'b1;
					cmd.mul_sel = MS_SQR;
					state_d = S_PSQW;
				end
			end
			S_PSQW: begin
				if (sts.mul_done) begin
					cmd.wb = WB_BASE;
					state_d = S_PTEST;
				end
			end
			S_FINISH: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

`ifndef NO_ASSERTIONS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_stall |-> !cmd.load_out)
		else $error("result register loaded while its item is still stalled");

	a_accept_setup: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> state_q == S_SETUP)
		else $error("accepted item did not move to decode");

	a_mul_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sts.mul_done |-> state_q == S_MULW || state_q == S_PMULW || state_q == S_PSQW)
		else $error("multiplier finished while the controller was not waiting");

	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> state_q == S_DIVW)
		else $error("divider finished while the controller was not waiting");
`endif

endmodule

`default_nettype wire
